// ===== rtl/core/text_console_cursor_scroll_assert.svh =====
// Assertion macros shared by the text console cursor and scroll block.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define TCCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked at every clock edge outside reset.
`define TCCS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

// ===== rtl/core/tccs_pkg.sv =====
// Package with shared types and constants of the text console block.
`timescale 1ns / 1ps

package tccs_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned COLOR_W  = 4;
  localparam int unsigned RADDR_W  = 11;
  localparam int unsigned CURSOR_W = 11;
  localparam int unsigned CELL_W   = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // capture the input beat
    logic exec;      // apply the captured item to cursor and cell store
    logic copy;      // one step of the scroll copy
    logic drain;     // last copy write, then point at the bottom row
    logic fill;      // write one blank cell
    logic load_out;  // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e act;
    logic    need_scroll;
    logic    copy_last;
    logic    fill_last;
    logic    out_free;
  } sts_t;

endpackage

// ===== rtl/core/tccs_in_if.sv =====
// Input channel of the text console: handshake plus one item.
`timescale 1ns / 1ps

interface tccs_in_if
  import tccs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ACTION_W-1:0] action;
  logic [CHAR_W-1:0]  char_code;
  logic [COLOR_W-1:0] bg_color;
  logic [COLOR_W-1:0] fg_color;
  logic [RADDR_W-1:0] read_addr;

  modport source (
    output valid, action, char_code, bg_color, fg_color, read_addr,
    input  ready
  );
  modport sink (
    input  valid, action, char_code, bg_color, fg_color, read_addr,
    output ready
  );
endinterface

// ===== rtl/core/tccs_out_if.sv =====
// Result channel of the text console: handshake plus one result.
`timescale 1ns / 1ps

interface tccs_out_if
  import tccs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_pos;
  logic [CELL_W-1:0]   read_data;
  logic                scrolled;

  modport source (
    output valid, cursor_pos, read_data, scrolled,
    input  ready
  );
  modport sink (
    input  valid, cursor_pos, read_data, scrolled,
    output ready
  );
endinterface

// ===== rtl/core/text_console_cursor_scroll.sv =====
// Top level of the text console engine with cursor, scroll and cell store.
`timescale 1ns / 1ps
//
//  Channel  Dir  Beat carries                                     Handshake
//  in_i     in   action, char_code, bg_color, fg_color,            valid/ready
//                read_addr
//  out_o    out  cursor_pos, read_data, scrolled                  valid/ready
//
//  A clear and a scrolling put are paced by the single write port of the
//  cell store, which the copy and the blank fill sweep one cell per cycle.
//  After reset a clearing pass fills the store with blanks; no beat is
//  taken during it.
//  The result register lets the next item be taken while a result waits;
//  an item that finishes into a full result register holds until it drains.
//
module text_console_cursor_scroll
  import tccs_pkg::*;
#(
  parameter int unsigned COLS     = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tccs_in_if.sink     in_i,
  tccs_out_if.source  out_o
);

  // The controller sees only status from the datapath and drives commands
  // back; all storage, cursor arithmetic and the result register live in
  // the datapath.
  cmd_t cmd;
  sts_t sts;

  tccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tccs_dpath #(
    .COLS     (COLS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .action_i     (in_i.action),
    .char_code_i  (in_i.char_code),
    .bg_color_i   (in_i.bg_color),
    .fg_color_i   (in_i.fg_color),
    .read_addr_i  (in_i.read_addr),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cursor_pos_o (out_o.cursor_pos),
    .read_data_o  (out_o.read_data),
    .scrolled_o   (out_o.scrolled)
  );

endmodule

// ===== rtl/core/tccs_ctrl.sv =====
// Controller state machine sequencing items, sweeps and the result handoff.
`timescale 1ns / 1ps
`include "text_console_cursor_scroll_assert.svh"

module tccs_ctrl
  import tccs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_FILL   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        unique case (sts_i.act)
          ACT_PUT: begin
            if (sts_i.need_scroll) begin
              state_d = S_COPY;
            end else if (sts_i.out_free) begin
              cmd_o.load_out = 1'b1;
              state_d        = S_IDLE;
            end else begin
              state_d = S_DONE;
            end
          end
          ACT_CLEAR: state_d = S_FILL;
          ACT_READ:  state_d = S_RDWAIT;
          ACT_NOP: begin
            if (sts_i.out_free) begin
              cmd_o.load_out = 1'b1;
              state_d        = S_IDLE;
            end else begin
              state_d = S_DONE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RDWAIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (sts_i.copy_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd_o.drain = 1'b1;
        state_d     = S_FILL;
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) begin
          if (sts_i.out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = S_IDLE;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The datapath owns a single write port, so sweep and item commands never overlap.
  `TCCS_ASSERT_ALWAYS(a_cmd_excl, clk_i, rst_ni, ($onehot0({cmd_o.take, cmd_o.exec, cmd_o.copy, cmd_o.drain, cmd_o.fill})), "datapath commands overlap")
  `TCCS_ASSERT_IMPL(a_load_free, clk_i, rst_ni, cmd_o.load_out, sts_i.out_free, "result loaded over an untaken result")

endmodule

// ===== rtl/core/tccs_dpath.sv =====
// Datapath: item register, cursor, cell store, sweep counter and result register.
`timescale 1ns / 1ps
`include "text_console_cursor_scroll_assert.svh"

module tccs_dpath
  import tccs_pkg::*;
#(
  parameter int unsigned COLS     = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [COLOR_W-1:0]  bg_color_i,
  input  logic [COLOR_W-1:0]  fg_color_i,
  input  logic [RADDR_W-1:0]  read_addr_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CURSOR_W-1:0] cursor_pos_o,
  output logic [CELL_W-1:0]   read_data_o,
  output logic                scrolled_o
);

  localparam int unsigned CELL_COUNT = COLS * ROWS;
  localparam int unsigned FILL_BASE  = (ROWS - 1) * COLS;
  localparam int unsigned COPY_LAST  = FILL_BASE - 1;
  localparam int unsigned AW = $clog2(CELL_COUNT);
  localparam int unsigned CW = $clog2(COLS + TAB_STOP);
  localparam int unsigned RW = $clog2(ROWS + 1);
  localparam int unsigned PW = $clog2(TAB_STOP);

  // Captured item.
  action_e             act_q;
  logic [CHAR_W-1:0]   char_q;
  logic [COLOR_W-1:0]  back_q;
  logic [COLOR_W-1:0]  fore_q;
  logic [RADDR_W-1:0]  raddr_q;

  // Cursor; phase_q tracks column modulo the tab stop.
  logic [CW-1:0] col_q, col_d, col_p;
  logic [RW-1:0] row_q, row_d, row_p;
  logic [PW-1:0] phase_q, phase_d, phase_p;
  logic          scr_q, scr_d;
  logic          need_scroll;

  logic [AW-1:0] cnt_q, pend_addr_q;
  logic          pend_q;

  logic [CELL_W-1:0] cells_q [CELL_COUNT];
  logic [CELL_W-1:0] rdata_q, wdata;
  logic [AW-1:0]     waddr, raddr, cur_addr;
  logic              we, re;
  logic              printable, addr_ok, put_exec;

  logic                out_valid_q;
  logic [CURSOR_W-1:0] pos_q;
  logic [CELL_W-1:0]   data_q;
  logic                scrolled_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      act_q   <= action_e'(action_i);
      char_q  <= char_code_i;
      back_q  <= bg_color_i;
      fore_q  <= fg_color_i;
      raddr_q <= read_addr_i;
    end
  end

  assign printable = !char_q[7] && (char_q[6:5] != 2'b00);
  assign addr_ok   = (32'(raddr_q) < CELL_COUNT);
  assign put_exec  = cmd_i.exec && (act_q == ACT_PUT);
  assign cur_addr  = AW'(32'(row_q) * COLS + 32'(col_q));

  // Cursor step for a put item, then the wrap and scroll checks.
  always_comb begin
    col_p       = col_q;
    row_p       = row_q;
    phase_p     = phase_q;
    need_scroll = 1'b0;
    priority if (char_q == CH_BS) begin
      if (col_q != '0) begin
        col_p   = col_q - CW'(1);
        phase_p = (phase_q == '0) ? PW'(TAB_STOP - 1) : phase_q - PW'(1);
      end
    end else if (char_q == CH_TAB) begin
      col_p   = col_q + CW'(TAB_STOP) - CW'(phase_q);
      phase_p = '0;
    end else if (char_q == CH_CR) begin
      col_p   = '0;
      phase_p = '0;
    end else if (char_q == CH_LF) begin
      col_p   = '0;
      phase_p = '0;
      row_p   = row_q + RW'(1);
    end else if (printable) begin
      col_p   = col_q + CW'(1);
      phase_p = (phase_q == PW'(TAB_STOP - 1)) ? '0 : phase_q + PW'(1);
    end
    if (col_p >= CW'(COLS)) begin
      col_p   = '0;
      phase_p = '0;
      row_p   = row_p + RW'(1);
    end
    if (row_p >= RW'(ROWS)) begin
      row_p       = RW'(ROWS - 1);
      need_scroll = 1'b1;
    end
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    phase_d = phase_q;
    scr_d   = scr_q;
    if (cmd_i.exec) begin
      scr_d = put_exec && need_scroll;
      if (put_exec) begin
        col_d   = col_p;
        row_d   = row_p;
        phase_d = phase_p;
      end else if (act_q == ACT_CLEAR) begin
        col_d   = '0;
        row_d   = '0;
        phase_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= '0;
      scr_q   <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
      scr_q   <= scr_d;
    end
  end

  // Sweep counter shared by the scroll copy and the blank fill.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.copy;
      priority if (cmd_i.exec) begin
        cnt_q <= '0;
      end else if (cmd_i.drain) begin
        cnt_q <= AW'(FILL_BASE);
      end else if (cmd_i.copy || cmd_i.fill) begin
        cnt_q <= cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= cnt_q;
  end

  // One write port: pending copy, blank fill or a stored character.
  always_comb begin
    we    = pend_q || cmd_i.fill || (put_exec && printable);
    waddr = cur_addr;
    wdata = {back_q, fore_q, char_q};
    priority if (pend_q) begin
      waddr = pend_addr_q;
      wdata = rdata_q;
    end else if (cmd_i.fill) begin
      waddr = cnt_q;
      wdata = BLANK_CELL;
    end
  end

  assign re    = cmd_i.copy || (cmd_i.exec && (act_q == ACT_READ) && addr_ok);
  assign raddr = cmd_i.copy ? cnt_q + AW'(COLS) : AW'(raddr_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      cells_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= cells_q[raddr];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pos_q      <= CURSOR_W'(32'(row_d) * COLS + 32'(col_d));
      data_q     <= ((act_q == ACT_READ) && addr_ok) ? rdata_q : '0;
      scrolled_q <= scr_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = pos_q;
  assign read_data_o  = data_q;
  assign scrolled_o   = scrolled_q;

  assign sts_o.act         = act_q;
  assign sts_o.need_scroll = need_scroll;
  assign sts_o.copy_last   = (cnt_q == AW'(COPY_LAST));
  assign sts_o.fill_last   = (cnt_q == AW'(CELL_COUNT - 1));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  `TCCS_ASSERT_ALWAYS(a_row_range, clk_i, rst_ni, (row_q < RW'(ROWS)), "cursor row off screen")
  `TCCS_ASSERT_ALWAYS(a_col_range, clk_i, rst_ni, (col_q < CW'(COLS)), "column off screen")
  `TCCS_ASSERT_IMPL(a_pend_excl, clk_i, rst_ni, pend_q, !(cmd_i.fill || cmd_i.exec), "write clash")

endmodule
